// ----- design/stack_queue_engine_top_defines.svh -----
// assertion macros for the stack and queue engine
`ifndef STACK_QUEUE_ENGINE_TOP_DEFINES_SVH
`define STACK_QUEUE_ENGINE_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define SQE_ASSERT_IMPLIES(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("sqe assertion failed");

`define SQE_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("sqe assertion failed");

`else

`define SQE_ASSERT_IMPLIES(label, clk, rst, cond, expr)

`define SQE_ASSERT_NEXT(label, clk, rst, cond, expr)

`endif

`endif

// ----- design/sqe_pkg.sv -----
// shared types and codes for the stack and queue engine
`default_nettype none

package sqe_pkg;

   localparam int DATA_W = 32;

   typedef enum logic [1:0] {
      OP_PUSH = 2'd0,
      OP_POP  = 2'd1,
      OP_PEEK = 2'd2,
      OP_LIST = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic read;
      logic list_start;
      logic list_step;
   } dp_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } dp_status_type;

   typedef struct packed {
      logic       valid;
      logic       has_value;
      status_type status;
      logic       last;
   } rsp_type;

endpackage

`default_nettype wire

// ----- design/sqe_ctrl.sv -----
// controller state machine: decodes transactions and sequences list output
`default_nettype none

module sqe_ctrl #(
   parameter int DEPTH = 64
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire sqe_pkg::op_type              op,
   input  wire sqe_pkg::dp_status_type       dp_status,
   input  wire logic [$clog2(DEPTH+1)-1:0]   count,
   output sqe_pkg::dp_cmd_type               cmd,
   output sqe_pkg::rsp_type                  rsp
);

   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic {
      S_IDLE,
      S_LIST
   } state_type;

   state_type          state_ff;
   logic [CW-1:0]      rem_ff;
   sqe_pkg::rsp_type   rsp_ff;

   assign busy = (state_ff == S_LIST);
   assign rsp  = rsp_ff;

   always_comb begin
      cmd = '0;
      if (state_ff == S_LIST) begin
         cmd.list_step = 1'b1;
      end else if (start) begin
         cmd.read = 1'b1;
         unique case (op)
            sqe_pkg::OP_PUSH: cmd.push       = !dp_status.full;
            sqe_pkg::OP_POP:  cmd.pop        = !dp_status.empty;
            sqe_pkg::OP_PEEK: cmd.read       = 1'b1;
            sqe_pkg::OP_LIST: cmd.list_start = !dp_status.empty;
            default:          cmd.read       = 1'b1;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rem_ff   <= '0;
         rsp_ff   <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               rsp_ff.valid     <= start;
               rsp_ff.has_value <= 1'b0;
               rsp_ff.status    <= sqe_pkg::ST_OK;
               rsp_ff.last      <= 1'b1;
               if (start) begin
                  unique case (op)
                     sqe_pkg::OP_PUSH: begin
                        if (dp_status.full) rsp_ff.status <= sqe_pkg::ST_FULL;
                     end
                     sqe_pkg::OP_POP: begin
                        if (dp_status.empty) rsp_ff.status <= sqe_pkg::ST_EMPTY;
                     end
                     sqe_pkg::OP_PEEK: begin
                        if (dp_status.empty) begin
                           rsp_ff.status <= sqe_pkg::ST_EMPTY;
                        end else begin
                           rsp_ff.has_value <= 1'b1;
                        end
                     end
                     sqe_pkg::OP_LIST: begin
                        if (!dp_status.empty) begin
                           rsp_ff.has_value <= 1'b1;
                           rsp_ff.last      <= (count == CW'(1));
                           rem_ff           <= count - CW'(1);
                           if (count != CW'(1)) state_ff <= S_LIST;
                        end
                     end
                     default: rsp_ff.status <= sqe_pkg::ST_OK;
                  endcase
               end
            end
            S_LIST: begin
               // one stored entry per cycle, top to bottom
               rsp_ff.valid     <= 1'b1;
               rsp_ff.has_value <= 1'b1;
               rsp_ff.status    <= sqe_pkg::ST_OK;
               rsp_ff.last      <= (rem_ff == CW'(1));
               rem_ff           <= rem_ff - CW'(1);
               if (rem_ff == CW'(1)) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

// ----- design/sqe_dp.sv -----
// datapath: circular entry memory, top pointer, entry count and mode register
`default_nettype none

module sqe_dp #(
   parameter int DEPTH = 64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire sqe_pkg::dp_cmd_type                 cmd,
   input  wire logic signed [sqe_pkg::DATA_W-1:0]   push_value,
   input  wire logic                                csr_write,
   input  wire logic                                csr_data,
   input  wire logic                                has_value,
   output sqe_pkg::dp_status_type                   dp_status,
   output logic [$clog2(DEPTH+1)-1:0]               count,
   output logic signed [sqe_pkg::DATA_W-1:0]        result_value
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;

   logic signed [sqe_pkg::DATA_W-1:0] mem [DEPTH];
   logic signed [sqe_pkg::DATA_W-1:0] rd_data_ff;

   logic [AW-1:0] top_ff;
   logic [CW-1:0] count_ff;
   logic          queue_mode_ff;
   logic [AW-1:0] rd_ptr_ff;

   logic [AW-1:0] top_inc;
   logic [AW-1:0] top_dec;
   logic [AW-1:0] rd_ptr_inc;
   logic [SW-1:0] tail_sum;
   logic [AW-1:0] tail_pos;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   logic          rd_en;

   assign top_inc    = (top_ff == AW'(DEPTH - 1)) ? '0 : top_ff + AW'(1);
   assign top_dec    = (top_ff == '0) ? AW'(DEPTH - 1) : top_ff - AW'(1);
   assign rd_ptr_inc = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);

   // slot below the bottom entry, top plus count stays under twice the depth
   assign tail_sum = SW'(top_ff) + SW'(count_ff);
   assign tail_pos = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);

   assign wr_addr = queue_mode_ff ? tail_pos : top_dec;
   assign rd_addr = cmd.list_step ? rd_ptr_ff : top_ff;
   assign rd_en   = cmd.read | cmd.list_step;

   assign dp_status.empty = (count_ff == '0);
   assign dp_status.full  = (count_ff == CW'(DEPTH));
   assign count           = count_ff;
   assign result_value    = has_value ? rd_data_ff : '0;

   always_ff @(posedge clock) begin
      if (cmd.push) mem[wr_addr] <= push_value;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff        <= '0;
         count_ff      <= '0;
         queue_mode_ff <= 1'b0;
         rd_ptr_ff     <= '0;
      end else begin
         if (csr_write) queue_mode_ff <= csr_data;
         if (cmd.push) begin
            count_ff <= count_ff + CW'(1);
            if (!queue_mode_ff) top_ff <= top_dec;
         end else if (cmd.pop) begin
            count_ff <= count_ff - CW'(1);
            top_ff   <= top_inc;
         end
         if (cmd.list_start) begin
            rd_ptr_ff <= top_inc;
         end else if (cmd.list_step) begin
            rd_ptr_ff <= rd_ptr_inc;
         end
      end
   end

endmodule

`default_nettype wire

// ----- design/stack_queue_engine_top.sv -----
// top level of the stack and queue engine
//
// Command channel: a transaction is taken at a rising edge with start high and
// busy low; req_mode selects push, pop, peek or list, req_push_value is the
// value for a push.
// Result channel: each result shows on the rsp_ ports for one cycle with
// rsp_strobe high; the receiver cannot hold results off.
// Config channel: csr_queue_mode is written when csr_valid and csr_ready are
// high; csr_ready is always high. The user makes writes while the block is
// idle; the block itself does not enforce this. Timing: the first result of a
// transaction appears in the cycle after it is taken. Push, pop and peek
// give one result and leave busy low, so one such transaction is taken
// every cycle. A list of N stored entries streams N results on consecutive
// cycles, one memory read per cycle from the single read port; busy is high
// while it streams and drops in the cycle of the last result, when the next transaction can be taken.
// Reset clears the entry count, top pointer and mode; the entry memory is not
// cleared and needs no clearing pass.
`default_nettype none

`include "stack_queue_engine_top_defines.svh"

module stack_queue_engine_top #(
   parameter int DEPTH = 64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [1:0]                          req_mode,
   input  wire logic signed [sqe_pkg::DATA_W-1:0]   req_push_value,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic                                csr_queue_mode,
   output logic                                     rsp_strobe,
   output logic signed [sqe_pkg::DATA_W-1:0]        rsp_result_value,
   output logic                                     rsp_has_value,
   output logic [1:0]                               rsp_status,
   output logic                                     rsp_last_result
);

   localparam int CW = $clog2(DEPTH + 1);

   sqe_pkg::dp_cmd_type    cmd;
   sqe_pkg::dp_status_type dp_status;
   sqe_pkg::rsp_type       rsp;
   logic [CW-1:0]          count;

   assign csr_ready = 1'b1;

   sqe_ctrl #(
      .DEPTH(DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .op        (sqe_pkg::op_type'(req_mode)),
      .dp_status (dp_status),
      .count     (count),
      .cmd       (cmd),
      .rsp       (rsp)
   );

   sqe_dp #(
      .DEPTH(DEPTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .push_value   (req_push_value),
      .csr_write    (csr_valid & csr_ready),
      .csr_data     (csr_queue_mode),
      .has_value    (rsp.has_value),
      .dp_status    (dp_status),
      .count        (count),
      .result_value (rsp_result_value)
   );

   assign rsp_strobe      = rsp.valid;
   assign rsp_has_value   = rsp.has_value;
   assign rsp_status      = rsp.status;
   assign rsp_last_result = rsp.last;

   `SQE_ASSERT_NEXT(a_accept_gives_result, clock, reset, start && !busy, rsp_strobe)
   `SQE_ASSERT_IMPLIES(a_list_streams, clock, reset, busy, rsp_strobe && !rsp_last_result)
   `SQE_ASSERT_IMPLIES(a_value_means_ok, clock, reset, rsp_strobe && rsp_has_value,
      rsp_status == 2'(sqe_pkg::ST_OK))

endmodule

`default_nettype wire
